// ===== sv/ita_pkg.sv =====
// Package for the integer to ASCII formatter.
// Item types, mode codes, character constants and digit lookup functions.
// No dependencies.
`default_nettype none

package ita_pkg;

  localparam logic [2:0] MODE_SDEC = 3'd0;
  localparam logic [2:0] MODE_UDEC = 3'd1;
  localparam logic [2:0] MODE_HEXL = 3'd2;
  localparam logic [2:0] MODE_HEXU = 3'd3;
  localparam logic [2:0] MODE_PTR  = 3'd4;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LPAR  = 8'h28;
  localparam logic [7:0] CHAR_N     = 8'h6E;
  localparam logic [7:0] CHAR_I     = 8'h69;
  localparam logic [7:0] CHAR_L     = 8'h6C;
  localparam logic [7:0] CHAR_RPAR  = 8'h29;

  localparam logic [4:0] NDIG_DEC = 5'd10;
  localparam logic [4:0] NDIG_HEX = 5'd8;
  localparam logic [4:0] NDIG_PTR = 5'd16;
  localparam logic [4:0] NDIG_NIL = 5'd5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  character;
    logic        last_char;
    logic [31:0] total_emitted;
  } out_item_t;

  // Classified job: hex digits left aligned, or decimal magnitude in the low word
  typedef struct packed {
    logic        is_dec;
    logic        upper;
    logic        neg;
    logic        nil;
    logic [4:0]  ndig;
    logic [63:0] value;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CHAR_ZERO + {4'b0, nib};
    end else if (upper) begin
      c = CHAR_UA + {4'b0, nib - 4'd10};
    end else begin
      c = CHAR_LA + {4'b0, nib - 4'd10};
    end
    return c;
  endfunction

  function automatic logic [7:0] nil_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CHAR_LPAR;
      3'd1:    c = CHAR_N;
      3'd2:    c = CHAR_I;
      3'd3:    c = CHAR_L;
      default: c = CHAR_RPAR;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ita_front.sv =====
// Front end of the formatter: accepts input items and classifies them into jobs.
// Depends on ita_pkg.
`default_nettype none

module ita_front (
  input  wire ita_pkg::in_item_t in_i,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire                    q_full_i,
  output ita_pkg::job_t          job_o,
  output logic                   push_o
);
  import ita_pkg::*;

  logic [31:0] low;
  logic        accept;
  logic        known;

  assign low        = in_i.value[31:0];
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept && known;

  always_comb begin
    known        = 1'b1;
    job_o.is_dec = 1'b0;
    job_o.upper  = 1'b0;
    job_o.neg    = 1'b0;
    job_o.nil    = 1'b0;
    job_o.ndig   = NDIG_HEX;
    job_o.value  = {low, 32'b0};
    unique case (in_i.mode)
      MODE_SDEC: begin
        job_o.is_dec = 1'b1;
        job_o.neg    = low[31];
        job_o.ndig   = NDIG_DEC;
        job_o.value  = {32'b0, low[31] ? (32'd0 - low) : low};
      end
      MODE_UDEC: begin
        job_o.is_dec = 1'b1;
        job_o.ndig   = NDIG_DEC;
        job_o.value  = {32'b0, low};
      end
      MODE_HEXL: begin
      end
      MODE_HEXU: begin
        job_o.upper = 1'b1;
      end
      MODE_PTR: begin
        job_o.value = in_i.value;
        if (in_i.value == 64'd0) begin
          job_o.nil  = 1'b1;
          job_o.ndig = NDIG_NIL;
        end else begin
          job_o.ndig = NDIG_PTR;
        end
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/ita_queue.sv =====
// Short job queue between the front and back ends of the formatter.
// Depends on ita_pkg.
`default_nettype none

module ita_queue #(
  parameter int Depth = 2
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           push_i,
  input  wire ita_pkg::job_t push_data_i,
  input  wire           pop_i,
  output ita_pkg::job_t head_o,
  output logic          empty_o,
  output logic          full_o
);
  import ita_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == DepthCnt);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ita_back.sv =====
// Back end of the formatter: decimal conversion, leading zero skip, character output.
// Depends on ita_pkg.
`default_nettype none

module ita_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire ita_pkg::job_t job_i,
  input  wire                empty_i,
  output logic               pop_o,
  output ita_pkg::out_item_t out_o,
  output logic               out_valid_o,
  input  wire                out_stall_i
);
  import ita_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [63:0] digits_q, digits_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [39:0] bcd_q, bcd_d, bcd_adj, bcd_next;
  logic [31:0] bin_q, bin_d;
  logic [4:0]  iter_q, iter_d;
  logic        upper_q, upper_d, neg_q, neg_d, nil_q, nil_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic [31:0] total_q, total_d;
  logic        slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;
  assign pop_o       = (state_q == ST_IDLE) && !empty_i;

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
                                                    : bcd_q[i*4 +: 4];
    end
    bcd_next = {bcd_adj[38:0], bin_q[31]};
  end

  always_comb begin
    state_d     = state_q;
    digits_d    = digits_q;
    cnt_d       = cnt_q;
    bcd_d       = bcd_q;
    bin_d       = bin_q;
    iter_d      = iter_q;
    upper_d     = upper_q;
    neg_d       = neg_q;
    nil_d       = nil_q;
    out_d       = out_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          upper_d  = job_i.upper;
          neg_d    = job_i.neg;
          nil_d    = job_i.nil;
          digits_d = job_i.value;
          cnt_d    = job_i.ndig;
          bin_d    = job_i.value[31:0];
          bcd_d    = '0;
          iter_d   = '0;
          if (job_i.is_dec) begin
            state_d = ST_CONV;
          end else if (job_i.nil) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_SKIP;
          end
        end
      end
      ST_CONV: begin
        bcd_d  = bcd_next;
        bin_d  = {bin_q[30:0], 1'b0};
        iter_d = iter_q + 5'd1;
        if (iter_q == 5'd31) begin
          digits_d = {bcd_next, 24'b0};
          cnt_d    = NDIG_DEC;
          state_d  = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (digits_q[63:60] == 4'd0 && cnt_q > 5'd1) begin
          digits_d = {digits_q[59:0], 4'b0};
          cnt_d    = cnt_q - 5'd1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d         = 1'b1;
          total_d             = total_q + 32'd1;
          out_d.total_emitted = total_q + 32'd1;
          if (neg_q) begin
            neg_d           = 1'b0;
            out_d.character = CHAR_MINUS;
            out_d.last_char = 1'b0;
          end else begin
            out_d.character = nil_q ? nil_char(3'(NDIG_NIL - cnt_q))
                                    : hex_char(digits_q[63:60], upper_q);
            out_d.last_char = (cnt_q == 5'd1);
            digits_d        = {digits_q[59:0], 4'b0};
            cnt_d           = cnt_q - 5'd1;
            if (cnt_q == 5'd1) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    cnt_q    <= cnt_d;
    bcd_q    <= bcd_d;
    bin_q    <= bin_d;
    iter_q   <= iter_d;
    upper_q  <= upper_d;
    neg_q    <= neg_d;
    nil_q    <= nil_d;
    out_q    <= out_d;
  end

endmodule

`default_nettype wire

// ===== sv/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter: front end, job queue, back end.
// Depends on ita_pkg, ita_front, ita_queue and ita_back.
`default_nettype none

// Formats one number per input item as ASCII, most significant character first,
// one output item per character, with last_char on the final one and a wrapping
// 32-bit count of all characters emitted. Modes: signed decimal, unsigned decimal,
// lower and upper case hex of the low 32 bits, and 64-bit pointer hex that prints
// "(nil)" for zero; modes 5 to 7 are accepted and dropped. A job queue of
// QueueDepth entries decouples input from output. In the back end a decimal item
// is loaded, converted by shift-and-add-3 and stripped of leading zeros, then
// emitted one character per cycle (sign included) while the output does not stall;
// a hex item is loaded, stripped of leading zero nibbles and emitted the same way,
// and "(nil)" is loaded and emitted with no skip step. The back end takes a new job
// from the queue only when idle, after it has issued the previous job's last character.
module integer_to_ascii_formatter #(
  parameter int QueueDepth = 2
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire ita_pkg::in_item_t in_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  output ita_pkg::out_item_t out_o,
  output logic               out_valid_o,
  input  wire                out_stall_i
);
  import ita_pkg::*;

  job_t push_job, head_job;
  logic push, pop, q_empty, q_full;

  ita_front u_front (
    .in_i       (in_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .job_o      (push_job),
    .push_o     (push)
  );

  ita_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .head_o      (head_job),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  ita_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_o       (out_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

`ifndef SYNTHESIS
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=>
      (!out_valid_o || out_o.total_emitted == $past(out_o.total_emitted) + 32'd1))
    else $error("character count did not advance by one");

  a_run_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_o.last_char) |=> out_valid_o)
    else $error("gap inside a character run");

  a_queue_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_empty && q_full))
    else $error("queue both empty and full");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_integer_to_ascii_formatter.sv =====
// Testbench for integer_to_ascii_formatter: directed and random numbers in every mode,
// each expected character predicted in the bench and checked in order as it leaves.
// Depends on ita_pkg and the formatter RTL only.
`timescale 1ns / 100ps

module tb_integer_to_ascii_formatter;
  import ita_pkg::*;

  localparam logic [2:0] MODE_RSVD_LO  = 3'd5;
  localparam logic [2:0] MODE_RSVD_MID = 3'd6;
  localparam logic [2:0] MODE_RSVD_HI  = 3'd7;

  localparam int NUM_RANDOM    = 185;
  localparam int QUIET_TAIL    = 30;
  localparam int HOLD_AFTER    = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 80;
  localparam int CYCLE_LIMIT   = 600000;

  class char_stream_checker;
    int unsigned char_count;
    out_item_t   pending_chars[$];
    int unsigned chars_checked;
    int          errors;

    function void report(string msg);
      if (errors < 10) $display("%s", msg);
      errors++;
    endfunction

    function void note_number(in_item_t it);
      logic [7:0]  text[$];
      logic [63:0] v;
      logic [63:0] base;
      logic [63:0] d;
      logic [31:0] low;
      logic        upper;
      logic        neg;
      out_item_t   exp_item;
      low   = it.value[31:0];
      upper = 1'b0;
      neg   = 1'b0;
      base  = 64'd16;
      v     = 64'd0;
      case (it.mode)
        MODE_SDEC: begin
          base = 64'd10;
          neg  = low[31];
          v    = {32'b0, (neg ? 32'd0 - low : low)};
        end
        MODE_UDEC: begin
          base = 64'd10;
          v    = {32'b0, low};
        end
        MODE_HEXL: v = {32'b0, low};
        MODE_HEXU: begin
          v     = {32'b0, low};
          upper = 1'b1;
        end
        MODE_PTR: v = it.value;
        default: return;
      endcase
      if (it.mode == MODE_PTR && v == 64'd0) begin
        text = '{CHAR_LPAR, CHAR_N, CHAR_I, CHAR_L, CHAR_RPAR};
      end else begin
        do begin
          d = v % base;
          if (d < 64'd10) text.push_front(CHAR_ZERO + d[7:0]);
          else text.push_front((upper ? CHAR_UA : CHAR_LA) + d[7:0] - 8'd10);
          v = v / base;
        end while (v != 64'd0);
        if (neg) text.push_front(CHAR_MINUS);
      end
      foreach (text[k]) begin
        char_count++;
        exp_item.character     = text[k];
        exp_item.last_char     = (k == text.size() - 1);
        exp_item.total_emitted = char_count;
        pending_chars.push_back(exp_item);
      end
    endfunction

    function void check_char(out_item_t got);
      out_item_t exp_item;
      chars_checked++;
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected item: char %h last %b total %0d",
                         got.character, got.last_char, got.total_emitted));
        return;
      end
      exp_item = pending_chars.pop_front();
      if (got.character !== exp_item.character || got.last_char !== exp_item.last_char ||
          got.total_emitted !== exp_item.total_emitted) begin
        report($sformatf("mismatch: char exp %h got %h, last exp %b got %b, total exp %0d got %0d",
                         exp_item.character, got.character, exp_item.last_char, got.last_char,
                         exp_item.total_emitted, got.total_emitted));
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  in_item_t  in_i        = '0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  out_item_t out_o;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;

  char_stream_checker sb = new();

  bit quiet_tail = 1'b0;
  bit hold_off   = 1'b0;
  int numbers_sent;
  int ignored_sent;
  int random_sent;
  int mode_hits[8];
  int unsigned cycle_count;

  integer_to_ascii_formatter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_o      (out_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding",
               cycle_count, sb.pending_chars.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_char(out_o);
  end

  // receiver: random stall bursts, calm stretches, and the long hold-off
  initial begin
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (calm_left > 0 || quiet_tail) begin
        if (calm_left > 0) calm_left--;
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(20, 60);
      end
    end
  end

  // hold off the receiver long enough for the block to fill and stall its input
  initial begin
    wait (numbers_sent >= HOLD_AFTER);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  task automatic drive_number(input logic [2:0] mode, input logic [63:0] value);
    in_item_t it;
    it = '{mode: mode, value: value};
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_i       <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_number(it);
    mode_hits[mode]++;
    if (mode <= MODE_PTR) numbers_sent++;
    else ignored_sent++;
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       return r >> 64 - $urandom_range(1, 8);
      1:       return {r[63:32], 32'h8000_0000 | (r[31:0] >> $urandom_range(1, 31))};
      2:       return {r[63:32], 32'hffff_ffff - {28'b0, r[3:0]}};
      default: return r >> $urandom_range(0, 64);
    endcase
  endfunction

  initial begin
    logic [2:0] mode;
    int pick;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drive_number(MODE_SDEC, 64'd0);
    drive_number(MODE_SDEC, 64'd1);
    drive_number(MODE_SDEC, 64'h0000_0000_ffff_ffff);
    drive_number(MODE_SDEC, 64'h0000_0000_7fff_ffff);
    drive_number(MODE_SDEC, 64'h0000_0000_8000_0000);
    drive_number(MODE_SDEC, 64'hffff_ffff_8000_0000);
    drive_number(MODE_UDEC, 64'd0);
    drive_number(MODE_UDEC, 64'h0000_0000_ffff_ffff);
    drive_number(MODE_UDEC, 64'haaaa_aaaa_0000_0009);
    drive_number(MODE_HEXL, 64'd0);
    drive_number(MODE_HEXL, 64'hffff_ffff_ffff_ffff);
    drive_number(MODE_HEXL, 64'h0000_0000_abcd_ef10);
    drive_number(MODE_HEXU, 64'h5555_5555_dead_beef);
    drive_number(MODE_HEXU, 64'h0000_0000_0000_000f);
    drive_number(MODE_HEXU, 64'hffff_ffff_0000_0000);
    drive_number(MODE_PTR, 64'd0);
    drive_number(MODE_PTR, 64'd1);
    drive_number(MODE_PTR, 64'hffff_ffff_ffff_ffff);
    drive_number(MODE_PTR, 64'h8000_0000_0000_0000);
    drive_number(MODE_PTR, 64'h0000_0001_0000_0000);
    drive_number(MODE_PTR, 64'hfedc_ba98_7654_3210);
    drive_number(MODE_RSVD_LO, 64'hffff_ffff_ffff_ffff);
    drive_number(MODE_RSVD_MID, 64'd0);
    drive_number(MODE_RSVD_HI, 64'h1234_5678_9abc_def0);

    while (random_sent < NUM_RANDOM) begin
      if (random_sent >= NUM_RANDOM - QUIET_TAIL) quiet_tail <= 1'b1;
      pick = $urandom_range(0, 10);
      if (pick == 10) mode = 3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
      else mode = 3'(pick % 5);
      drive_number(mode, random_value());
      if (mode <= MODE_PTR) random_sent++;
    end
    in_valid_i <= 1'b0;

    while (sb.pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.pending_chars.size() != 0) begin
      sb.report($sformatf("%0d characters never arrived", sb.pending_chars.size()));
    end
    $display("formatted %0d numbers (sdec %0d, udec %0d, hexl %0d, hexu %0d, ptr %0d), %0d dropped",
             numbers_sent, mode_hits[MODE_SDEC], mode_hits[MODE_UDEC], mode_hits[MODE_HEXL],
             mode_hits[MODE_HEXU], mode_hits[MODE_PTR], ignored_sent);
    $display("checked %0d characters in %0d cycles, %0d mismatches",
             sb.chars_checked, cycle_count, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
